FILE: rtl/core/bitx_pkg.sv
// ----------------------------------------------------------------------------
// Bitonal transpose package
// Shared constants for the bitonal image transpose unit.
// ----------------------------------------------------------------------------
package bitx_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int DIM_W      = 11;
  localparam int PIX_W      = 8;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_IN_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IN_HEIGHT = 2'd1;
  localparam logic [1:0] REG_REV_COLS  = 2'd2;
  localparam logic [1:0] REG_REV_ROWS  = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

endpackage

FILE: rtl/core/bitonal_image_transpose_unit.sv
// ----------------------------------------------------------------------------
// Bitonal image transpose unit
// Loads a packed 1-bit image in raster order and returns its transpose,
// optionally mirrored, one packed byte per fetch word.
// ----------------------------------------------------------------------------
// Load words stream at one word per cycle while no fetch is in progress.
// A fetch word passes a row-address multiply, a base add, up to eight reads
// of the single-port image memory through one shared address adder, a step
// for the last read data, and the output handoff to the result register.
// No new word is taken until the fetch has been handed off, and the handoff
// waits while the output is stalled. A fetch before the image is complete
// goes straight to the handoff and returns a zero not-ready word.
// Synchronous active-low reset clears all control state; the image memory is
// not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module bitonal_image_transpose_unit #(
  parameter int MAX_WIDTH  = bitx_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bitx_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: in_byte[7:0]
  input  logic [bitx_pkg::PIX_W-1:0]      in_tdata,
  // in_tuser: operation[0]
  input  logic                            in_tuser,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // out_tdata: out_byte[7:0]
  output logic [bitx_pkg::PIX_W-1:0]      out_tdata,
  // out_tuser: end_of_row[0], not_ready[1]
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [bitx_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bitx_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bitx_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  import bitx_pkg::*;

  localparam int ROW_BYTES_MAX = (MAX_WIDTH + 7) / 8;
  localparam int OUT_BYTES_MAX = (MAX_HEIGHT + 7) / 8;
  localparam int DEPTH         = ROW_BYTES_MAX * MAX_HEIGHT;
  localparam int AW            = $clog2(DEPTH);
  localparam int WW            = $clog2(MAX_WIDTH + 1);
  localparam int HW            = $clog2(MAX_HEIGHT + 1);
  localparam int RBW           = $clog2(ROW_BYTES_MAX + 1);
  localparam int OBW           = $clog2(OUT_BYTES_MAX + 1);
  localparam int CW            = $clog2(MAX_HEIGHT + 16);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_BASE   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [DIM_W-1:0] width_r, height_r;
  logic             rev_cols_r, rev_rows_r;

  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    load_pos_r, load_pos_nxt;
  logic [RBW-1:0]   load_col_r, load_col_nxt;
  logic [HW-1:0]    load_row_r, load_row_nxt;
  logic             loaded_r, loaded_nxt;
  logic [WW-1:0]    orow_r, orow_nxt;
  logic [OBW-1:0]   obyte_r, obyte_nxt;

  logic [HW-1:0]    irow0_r, irow0_nxt;
  logic [WW-1:0]    jcol_r, jcol_nxt;
  logic [CW-1:0]    c_r, c_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  logic             rd_en_d_r, rd_en_d_nxt;
  logic [PIX_W-1:0] res_r, res_nxt;
  logic             nr_r, nr_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_byte_r, out_byte_nxt;
  logic             out_eor_r, out_eor_nxt;
  logic             out_eoi_r, out_eoi_nxt;
  logic             out_nr_r, out_nr_nxt;

  logic [WW-1:0]     w_dim;
  logic [HW-1:0]     h_dim;
  logic [RBW-1:0]    irb;
  logic [OBW-1:0]    orb;
  logic              cfg_wr;
  logic              in_acc;
  logic              out_free;
  logic              rd_en;
  logic              ram_en, ram_we;
  logic [AW-1:0]     ram_addr;
  logic [PIX_W-1:0]  ram_rdata;
  logic [CW-1:0]     c0;
  logic [CW-1:0]     irow_rev;
  logic [HW+RBW-1:0] prod;
  logic              eor, eoi;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    if (width_r == '0) begin
      w_dim = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_dim = WW'(MAX_WIDTH);
    end else begin
      w_dim = WW'(width_r);
    end
    if (height_r == '0) begin
      h_dim = HW'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_dim = HW'(MAX_HEIGHT);
    end else begin
      h_dim = HW'(height_r);
    end
    irb = RBW'((32'(w_dim) + 32'd7) >> 3);
    orb = OBW'((32'(h_dim) + 32'd7) >> 3);
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[3:2])
      REG_IN_WIDTH:  cfg_prdata[DIM_W-1:0] = width_r;
      REG_IN_HEIGHT: cfg_prdata[DIM_W-1:0] = height_r;
      REG_REV_COLS:  cfg_prdata[0] = rev_cols_r;
      REG_REV_ROWS:  cfg_prdata[0] = rev_rows_r;
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= DIM_W'(1);
      height_r   <= DIM_W'(1);
      rev_cols_r <= 1'b0;
      rev_rows_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_IN_WIDTH:  width_r    <= cfg_pwdata[DIM_W-1:0];
        REG_IN_HEIGHT: height_r   <= cfg_pwdata[DIM_W-1:0];
        REG_REV_COLS:  rev_cols_r <= cfg_pwdata[0];
        REG_REV_ROWS:  rev_rows_r <= cfg_pwdata[0];
        default:       width_r    <= width_r;
      endcase
    end
  end

  assign c0       = CW'({obyte_r, 3'b000});
  assign irow_rev = CW'(h_dim) - CW'(1) - c0;
  assign prod     = irow0_r * irb;
  assign rd_en    = (state_r == S_READ) && (cnt_r < 4'd8) && (c_r < CW'(h_dim));
  assign eor      = (obyte_r == orb - OBW'(1));
  assign eoi      = eor && (orow_r >= w_dim - WW'(1));

  assign ram_we   = in_acc && (in_tuser == OP_LOAD) && !loaded_r;
  assign ram_en   = ram_we || rd_en;
  assign ram_addr = (state_r == S_IDLE) ? load_pos_r : addr_r;

  always_comb begin
    state_nxt     = state_r;
    load_pos_nxt  = load_pos_r;
    load_col_nxt  = load_col_r;
    load_row_nxt  = load_row_r;
    loaded_nxt    = loaded_r;
    orow_nxt      = orow_r;
    obyte_nxt     = obyte_r;
    irow0_nxt     = irow0_r;
    jcol_nxt      = jcol_r;
    c_nxt         = c_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    rd_en_d_nxt   = rd_en;
    res_nxt       = res_r;
    nr_nxt        = nr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_eor_nxt   = out_eor_r;
    out_eoi_nxt   = out_eoi_r;
    out_nr_nxt    = out_nr_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_LOAD) begin
            if (!loaded_r) begin
              load_pos_nxt = load_pos_r + AW'(1);
              if (load_col_r == irb - RBW'(1)) begin
                load_col_nxt = '0;
                load_row_nxt = load_row_r + HW'(1);
                if (load_row_r == h_dim - HW'(1)) begin
                  loaded_nxt = 1'b1;
                end
              end else begin
                load_col_nxt = load_col_r + RBW'(1);
              end
            end
          end else if (!loaded_r) begin
            res_nxt   = '0;
            nr_nxt    = 1'b1;
            state_nxt = S_FINISH;
          end else begin
            irow0_nxt = rev_cols_r ? HW'(irow_rev) : HW'(c0);
            jcol_nxt  = rev_rows_r ? (w_dim - WW'(1) - orow_r) : orow_r;
            c_nxt     = c0;
            nr_nxt    = 1'b0;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        addr_nxt  = AW'(prod);
        state_nxt = S_BASE;
      end
      S_BASE: begin
        addr_nxt  = addr_r + AW'(jcol_r >> 3);
        cnt_nxt   = '0;
        res_nxt   = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        if (cnt_r != 4'd0) begin
          res_nxt = {res_r[PIX_W-2:0],
                     rd_en_d_r ? ram_rdata[3'd7 - jcol_r[2:0]] : 1'b0};
        end
        if (cnt_r == 4'd8) begin
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt  = cnt_r + 4'd1;
          c_nxt    = c_r + CW'(1);
          addr_nxt = rev_cols_r ? (addr_r - AW'(irb)) : (addr_r + AW'(irb));
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = res_r;
          out_nr_nxt    = nr_r;
          out_eor_nxt   = !nr_r && eor;
          out_eoi_nxt   = !nr_r && eoi;
          state_nxt     = S_IDLE;
          if (!nr_r) begin
            if (eoi) begin
              load_pos_nxt = '0;
              load_col_nxt = '0;
              load_row_nxt = '0;
              loaded_nxt   = 1'b0;
              orow_nxt     = '0;
              obyte_nxt    = '0;
            end else if (eor) begin
              obyte_nxt = '0;
              orow_nxt  = orow_r + WW'(1);
            end else begin
              obyte_nxt = obyte_r + OBW'(1);
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cfg_wr && (cfg_paddr[3:2] == REG_IN_WIDTH || cfg_paddr[3:2] == REG_IN_HEIGHT ||
                   cfg_paddr[3:2] == REG_REV_COLS || cfg_paddr[3:2] == REG_REV_ROWS)) begin
      load_pos_nxt = '0;
      load_col_nxt = '0;
      load_row_nxt = '0;
      loaded_nxt   = 1'b0;
      orow_nxt     = '0;
      obyte_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_pos_r  <= '0;
      load_col_r  <= '0;
      load_row_r  <= '0;
      loaded_r    <= 1'b0;
      orow_r      <= '0;
      obyte_r     <= '0;
      cnt_r       <= '0;
      rd_en_d_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_pos_r  <= load_pos_nxt;
      load_col_r  <= load_col_nxt;
      load_row_r  <= load_row_nxt;
      loaded_r    <= loaded_nxt;
      orow_r      <= orow_nxt;
      obyte_r     <= obyte_nxt;
      cnt_r       <= cnt_nxt;
      rd_en_d_r   <= rd_en_d_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    irow0_r    <= irow0_nxt;
    jcol_r     <= jcol_nxt;
    c_r        <= c_nxt;
    addr_r     <= addr_nxt;
    res_r      <= res_nxt;
    nr_r       <= nr_nxt;
    out_byte_r <= out_byte_nxt;
    out_eor_r  <= out_eor_nxt;
    out_eoi_r  <= out_eoi_nxt;
    out_nr_r   <= out_nr_nxt;
  end

  bitx_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(in_tdata),
    .rdata(ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_nr_r, out_eor_r};
  assign out_tlast  = out_eoi_r;

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_IDLE)
    else $error("image store written outside idle");

  a_read_pending: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en_d_r |-> state_r == S_READ)
    else $error("read data returned outside read phase");

  a_finish_hand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (state_r == S_IDLE && out_valid_r))
    else $error("result not handed to output register");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !loaded_r |-> load_row_r < h_dim)
    else $error("load row ran past image height");

  a_nr_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_nr_r) |-> (!out_eor_r && !out_eoi_r && out_byte_r == '0))
    else $error("not-ready word carries data or marks");

endmodule

FILE: rtl/core/bitx_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module bitx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
